// ===== rtl/core/wql_pkg.sv =====
// ----------------------------------------------------------------------------
// wql_pkg
// Shared constants, codes and structs for the ordered wait queue.
// ----------------------------------------------------------------------------
package wql_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int ID_W       = 6;
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 2;
    localparam int POS_W      = 5;
    localparam int LEN_W      = 6;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NULL_ID   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_HEAD_RD,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ID_W-1:0]  wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [POS_W-1:0] position;
        logic [ID_W-1:0]  head_id;
        logic [LEN_W-1:0] length;
    } result_t;

endpackage

// ===== rtl/core/wql_ram.sv =====
// ----------------------------------------------------------------------------
// wql_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wql_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 6
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/wql_seq.sv =====
// ----------------------------------------------------------------------------
// wql_seq
// Request sequencer: decodes a request, scans the slot memory for a match,
// compacts the line after a removal and fetches the head for the result.
// ----------------------------------------------------------------------------
module wql_seq
    import wql_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ACT_W-1:0]  s_action,
    input  logic [ID_W-1:0]   s_entry_id,
    output ram_req_t          ram_req,
    input  logic [ID_W-1:0]   ram_rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    state_t           state_reg, state_next;
    action_t          act_reg, act_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             pend_reg, pend_next;
    status_t          status_reg, status_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] pos_reg, pos_next;

    logic             accept;
    logic             rd_more;
    logic             hit;
    logic             is_full;
    logic             needs_scan;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign rd_more    = (rd_idx_reg < count_reg);
    assign hit        = pend_reg && (ram_rdata == id_reg);
    assign is_full    = (count_reg == CNT_W'(LINE_DEPTH));
    assign needs_scan = (s_entry_id != '0) &&
                        ((action_t'(s_action) == ACT_REMOVE) ||
                         (action_t'(s_action) == ACT_QUERY));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        id_reg      <= id_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = needs_scan ? ST_SCAN : ST_HEAD_RD;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    state_next = (act_reg == ACT_REMOVE) ? ST_SHIFT : ST_HEAD_RD;
                end else if (!rd_more) begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_SHIFT: begin
                if (!rd_more) begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        act_next     = act_reg;
        id_next      = id_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = pend_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        ram_req      = '0;
        res_valid    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    act_next    = action_t'(s_action);
                    id_next     = s_entry_id;
                    status_next = STAT_OK;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    if (action_t'(s_action) == ACT_CLEAR) begin
                        count_next = '0;
                    end else if (s_entry_id == '0) begin
                        status_next = STAT_NULL_ID;
                    end else if (action_t'(s_action) == ACT_APPEND) begin
                        if (is_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = count_reg[IDX_W-1:0];
                            ram_req.wdata = s_entry_id;
                            pos_next      = count_reg[IDX_W-1:0];
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_SCAN: begin
                // Reads run one slot ahead of the compare.
                if (hit) begin
                    pend_next = 1'b0;
                    if (act_reg == ACT_QUERY) begin
                        found_next = 1'b1;
                        pos_next   = cmp_idx_reg;
                    end
                end else if (rd_more) begin
                    ram_req.re   = 1'b1;
                    ram_req.raddr = rd_idx_reg[IDX_W-1:0];
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (act_reg == ACT_REMOVE) begin
                        status_next = STAT_NOT_FOUND;
                    end
                end
            end
            ST_SHIFT: begin
                // Each slot read here is written one place forward in the cycle after its read.
                if (pend_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = cmp_idx_reg - IDX_W'(1);
                    ram_req.wdata = ram_rdata;
                end
                if (rd_more) begin
                    ram_req.re   = 1'b1;
                    ram_req.raddr = rd_idx_reg[IDX_W-1:0];
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_HEAD_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = '0;
            end
            ST_RESULT: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.status   = status_reg;
        res.found    = found_reg;
        res.position = POS_W'(pos_reg);
        res.head_id  = (count_reg != '0) ? ram_rdata : '0;
        res.length   = LEN_W'(count_reg);
    end

endmodule

// ===== rtl/core/ordered_wait_queue_with_removal.sv =====
// ----------------------------------------------------------------------------
// ordered_wait_queue_with_removal
// Ordered line of entry ids in a slot memory, with append, remove, query
// and clear requests; each request gives one result.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_action, s_entry_id
//  m_        out        m_valid/m_ready    m_status, m_found, m_position,
//                                          m_head_id, m_length
//
// Append, clear and null-id requests go straight to the head read. Query and
// remove scan the slot memory one slot per cycle, and a remove of a present id
// then compacts the line, moving each later slot one place forward. The
// single-read-port slot memory sets the pace of the scan and the compaction.
// Reset empties the line at once; the slot memory needs no clearing pass.
// A stalled result waits in the output register while the next request is
// accepted and processed up to its result.
// ----------------------------------------------------------------------------
module ordered_wait_queue_with_removal
    import wql_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ACT_W-1:0]  s_action,
    input  logic [ID_W-1:0]   s_entry_id,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic              m_found,
    output logic [POS_W-1:0]  m_position,
    output logic [ID_W-1:0]   m_head_id,
    output logic [LEN_W-1:0]  m_length
);

    ram_req_t        ram_req;
    logic [ID_W-1:0] ram_rdata;
    logic            res_valid;
    logic            res_ready;
    result_t         res;

    logic            m_valid_reg, m_valid_next;
    result_t         m_res_reg, m_res_next;
    logic            load;

    wql_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_entry_id (s_entry_id),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    wql_ram #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (ID_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_comb begin
        m_res_next   = m_res_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_res_next   = res;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_res_reg.status;
    assign m_found    = m_res_reg.found;
    assign m_position = m_res_reg.position;
    assign m_head_id  = m_res_reg.head_id;
    assign m_length   = m_res_reg.length;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered wait queue. Requests go in on the s_
// channel; a line model in the bench predicts each result, and every result
// taken from the m_ channel is compared field by field, in order, with it.
// ----------------------------------------------------------------------------
module tb_top
    import wql_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [ACT_W-1:0]  s_action;
    logic [ID_W-1:0]   s_entry_id;
    logic              m_valid;
    logic              m_ready;
    logic [STAT_W-1:0] m_status;
    logic              m_found;
    logic [POS_W-1:0]  m_position;
    logic [ID_W-1:0]   m_head_id;
    logic [LEN_W-1:0]  m_length;

    ordered_wait_queue_with_removal u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_entry_id (s_entry_id),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_found    (m_found),
        .m_position (m_position),
        .m_head_id  (m_head_id),
        .m_length   (m_length)
    );

    // Model of the line: ids packed from slot 0, plus the occupied count.
    logic [ID_W-1:0] line_ids [LINE_DEPTH];
    int              line_len;

    result_t pending_results [$];
    result_t want;
    int      err_count;
    bit      src_gaps_on;
    bit      snk_gaps_on;
    int      hold_off_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic result_t predict_line(input action_t act,
                                             input logic [ID_W-1:0] id);
        result_t r;
        int      hit;
        r   = '0;
        hit = -1;
        if (act == ACT_CLEAR) begin
            foreach (line_ids[i]) line_ids[i] = '0;
            line_len = 0;
        end else if (id == '0) begin
            r.status = STAT_NULL_ID;
        end else if (act == ACT_APPEND) begin
            if (line_len >= LINE_DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                line_ids[line_len] = id;
                r.position = POS_W'(line_len);
                line_len++;
            end
        end else begin
            for (int i = 0; i < line_len; i++) begin
                if (hit < 0 && line_ids[i] == id) hit = i;
            end
            if (act == ACT_REMOVE) begin
                if (hit < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    for (int i = hit; i < line_len - 1; i++) line_ids[i] = line_ids[i + 1];
                    line_ids[line_len - 1] = '0;
                    line_len--;
                end
            end else if (hit >= 0) begin
                r.found    = 1'b1;
                r.position = POS_W'(hit);
            end
        end
        r.head_id = (line_len > 0) ? line_ids[0] : '0;
        r.length  = LEN_W'(line_len);
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        err_count++;
        $display("ERROR at %0t ns: %s", $realtime, msg);
    endtask

    // Offers one request and holds it until taken. Valid is left high when no
    // gap follows, so the next request must be issued at once or the sender
    // must be stopped by drain_results.
    task automatic issue_request(input action_t act, input logic [ID_W-1:0] id);
        int gap;
        s_valid    <= 1'b1;
        s_action   <= act;
        s_entry_id <= id;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_line(act, id));
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [ID_W-1:0] any_id();
        return ID_W'($urandom_range(1, (1 << ID_W) - 1));
    endfunction

    function automatic logic [ID_W-1:0] present_id();
        return line_ids[$urandom_range(0, line_len - 1)];
    endfunction

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    note_mismatch($sformatf("status got %0d want %0d",
                                            m_status, int'(want.status)));
                if (m_found !== want.found)
                    note_mismatch($sformatf("found got %0d want %0d", m_found, want.found));
                if (m_position !== want.position)
                    note_mismatch($sformatf("position got %0d want %0d",
                                            m_position, want.position));
                if (m_head_id !== want.head_id)
                    note_mismatch($sformatf("head_id got %0d want %0d",
                                            m_head_id, want.head_id));
                if (m_length !== want.length)
                    note_mismatch($sformatf("length got %0d want %0d", m_length, want.length));
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                stall_left      = hold_off_cycles;
                hold_off_cycles = 0;
            end else if (stall_left == 0 && snk_gaps_on) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_empty_and_null();
        issue_request(ACT_CLEAR, '0);
        issue_request(ACT_APPEND, '0);
        issue_request(ACT_REMOVE, '0);
        issue_request(ACT_QUERY, '0);
        issue_request(ACT_REMOVE, 6'd7);
        issue_request(ACT_QUERY, 6'd7);
        drain_results();
    endtask

    task automatic test_order_and_duplicates();
        issue_request(ACT_APPEND, 6'd1);
        issue_request(ACT_APPEND, 6'd63);
        issue_request(ACT_APPEND, 6'd32);
        issue_request(ACT_APPEND, 6'd33);
        issue_request(ACT_APPEND, 6'd1);
        issue_request(ACT_QUERY, 6'd1);
        issue_request(ACT_QUERY, 6'd33);
        issue_request(ACT_REMOVE, 6'd1);
        issue_request(ACT_QUERY, 6'd1);
        issue_request(ACT_REMOVE, 6'd63);
        issue_request(ACT_APPEND, '0);
        issue_request(ACT_QUERY, 6'd9);
        issue_request(ACT_REMOVE, 6'd9);
        issue_request(ACT_CLEAR, 6'd42);
        issue_request(ACT_QUERY, 6'd32);
        drain_results();
    endtask

    task automatic test_full_line();
        for (int i = 0; i < LINE_DEPTH; i++) begin
            issue_request(ACT_APPEND, (i == LINE_DEPTH - 1) ? 6'd63 : ID_W'(i + 1));
        end
        issue_request(ACT_APPEND, 6'd5);
        issue_request(ACT_QUERY, 6'd63);
        // Removing the head moves every other entry one slot forward.
        issue_request(ACT_REMOVE, 6'd1);
        issue_request(ACT_APPEND, 6'd50);
        issue_request(ACT_APPEND, 6'd51);
        issue_request(ACT_REMOVE, 6'd50);
        issue_request(ACT_QUERY, 6'd2);
        issue_request(ACT_CLEAR, '0);
        drain_results();
    endtask

    task automatic issue_random_request(input int append_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            issue_request(ACT_CLEAR, ID_W'($urandom_range(0, (1 << ID_W) - 1)));
        end else if (r < 7) begin
            issue_request(action_t'($urandom_range(0, 2)), '0);
        end else if (r < 7 + append_pct) begin
            issue_request(ACT_APPEND,
                          (line_len > 0 && $urandom_range(0, 4) == 0) ? present_id() : any_id());
        end else begin
            issue_request(($urandom_range(0, 1) == 0) ? ACT_REMOVE : ACT_QUERY,
                          (line_len > 0 && $urandom_range(0, 3) != 0) ? present_id() : any_id());
        end
    endtask

    task automatic test_output_stall();
        src_gaps_on     = 1'b0;
        hold_off_cycles = 300;
        for (int i = 0; i < 40; i++) issue_random_request(45);
        drain_results();
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 14; chunk++) begin
            // Some stretches run with no idling on one or both sides.
            src_gaps_on = ($urandom_range(0, 3) != 0);
            snk_gaps_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 50; i++) issue_random_request($urandom_range(25, 60));
            if ($urandom_range(0, 3) == 0) drain_results();
        end
        drain_results();
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_action        = ACT_APPEND;
        s_entry_id      = '0;
        m_ready         = 1'b0;
        err_count       = 0;
        hold_off_cycles = 0;
        src_gaps_on     = 1'b1;
        snk_gaps_on     = 1'b1;
        foreach (line_ids[i]) line_ids[i] = '0;
        line_len = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_null();
        test_order_and_duplicates();
        test_full_line();
        test_output_stall();
        test_random_traffic();

        drain_results();
        repeat (60) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
